// File: hw/rtl/dmsp_pkg.sv
// Shared types and constants for the dual motor speed PID block.
// Used by the interfaces, the controller, the datapath and the top level.
`timescale 1ns / 1ps

package dmsp_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int MEAS_W     = 15;
  localparam int TIME_W     = 32;
  localparam int DRIVE_W    = 16;
  localparam int ISUM_W     = 32;
  localparam int FRAC_BITS  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST     = GAIN_W'(256);
  localparam logic [GAIN_W-1:0]  INTEGRAL_GAIN_RST = GAIN_W'(0);
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST    = GAIN_W'(0);
  localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST   = LIMIT_W'(255);

  // operand pair on the shared multiplier
  typedef enum logic [1:0] {
    MUL_ERR_TIME,
    MUL_PROP,
    MUL_INTEG,
    MUL_DERIV
  } mul_sel_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integral_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] drive_limit;
  } cfg_regs_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     isum_en;
    logic     acc_clr;
    logic     acc_add;
    logic     div_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/dmsp_in_if.sv
// Input channel: one speed update word per handshake.
// Depends on dmsp_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface dmsp_in_if #(
  parameter int SPEED_BITS = 16
);
  logic                              valid;
  logic                              ready;
  logic                              motor_sel;
  logic signed [SPEED_BITS-1:0]      desired_speed;
  logic [dmsp_pkg::MEAS_W-1:0]       measured_speed;
  logic [dmsp_pkg::TIME_W-1:0]       time_ms;

  modport source (output valid, motor_sel, desired_speed, measured_speed, time_ms,
                  input ready);
  modport sink   (input valid, motor_sel, desired_speed, measured_speed, time_ms,
                  output ready);
endinterface

// File: hw/rtl/dmsp_out_if.sv
// Result channel: one drive word per handshake.
// Depends on dmsp_pkg for the fixed field widths.
`timescale 1ns / 1ps

interface dmsp_out_if;
  logic                               valid;
  logic                               ready;
  logic                               motor_out;
  logic signed [dmsp_pkg::DRIVE_W-1:0] drive;
  logic                               clamped;

  modport source (output valid, motor_out, drive, clamped, input ready);
  modport sink   (input valid, motor_out, drive, clamped, output ready);
endinterface

// File: hw/rtl/dmsp_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on dmsp_pkg for the index and data widths.
`timescale 1ns / 1ps

interface dmsp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dmsp_pkg::CFG_IDX_W-1:0]    index;
  logic [dmsp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/dmsp_ctrl.sv
// Sequencer for one speed update: multiply steps, divide wait, result hand-off.
// Depends on dmsp_pkg for the command and status structs.
`timescale 1ns / 1ps

module dmsp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dmsp_pkg::dp_status_t status,
  output dmsp_pkg::dp_cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MULIE = 4'd1;
  localparam logic [3:0] ST_ISUM  = 4'd2;
  localparam logic [3:0] ST_ACCP  = 4'd3;
  localparam logic [3:0] ST_ACCI  = 4'd4;
  localparam logic [3:0] ST_DIVW  = 4'd5;
  localparam logic [3:0] ST_MULD  = 4'd6;
  localparam logic [3:0] ST_ACCD  = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = dmsp_pkg::MUL_ERR_TIME;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MULIE;
        end
      end
      ST_MULIE: begin
        cmd.mul_sel   = dmsp_pkg::MUL_ERR_TIME;
        cmd.div_start = 1'b1;
        state_nxt     = ST_ISUM;
      end
      ST_ISUM: begin
        cmd.isum_en = 1'b1;
        cmd.mul_sel = dmsp_pkg::MUL_PROP;
        state_nxt   = ST_ACCP;
      end
      ST_ACCP: begin
        cmd.acc_clr = 1'b1;
        cmd.mul_sel = dmsp_pkg::MUL_INTEG;
        state_nxt   = ST_ACCI;
      end
      ST_ACCI: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_DIVW;
      end
      ST_DIVW: begin
        if (!status.div_busy) begin
          state_nxt = ST_MULD;
        end
      end
      ST_MULD: begin
        cmd.mul_sel = dmsp_pkg::MUL_DERIV;
        state_nxt   = ST_ACCD;
      end
      ST_ACCD: begin
        cmd.acc_add = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/dmsp_dp.sv
// Datapath: per-motor state, shared multiplier, accumulator, serial divider,
// clamp and output register. Depends on dmsp_pkg; driven by dmsp_ctrl.
`timescale 1ns / 1ps

module dmsp_dp #(
  parameter int MOTOR_COUNT = 2,
  parameter int SPEED_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dmsp_pkg::dp_cmd_t                   cmd,
  output dmsp_pkg::dp_status_t                status,
  input  dmsp_pkg::cfg_regs_t                 cfg,
  input  logic                                in_motor_sel,
  input  logic signed [SPEED_BITS-1:0]        in_desired_speed,
  input  logic [dmsp_pkg::MEAS_W-1:0]         in_measured_speed,
  input  logic [dmsp_pkg::TIME_W-1:0]         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_motor_out,
  output logic signed [dmsp_pkg::DRIVE_W-1:0] out_drive,
  output logic                                out_clamped
);

  localparam int TW   = dmsp_pkg::TIME_W;
  localparam int EW   = ((SPEED_BITS > dmsp_pkg::MEAS_W) ? SPEED_BITS : dmsp_pkg::MEAS_W) + 1;
  localparam int AW   = TW + 1;
  localparam int BW   = (EW > dmsp_pkg::GAIN_W + 1) ? EW : dmsp_pkg::GAIN_W + 1;
  localparam int PW   = AW + BW;
  localparam int ACW  = PW + 2;
  localparam int QW   = EW;
  localparam int DCW  = $clog2(QW + 1);
  localparam int MIW  = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
  localparam int IW   = dmsp_pkg::ISUM_W;
  localparam int DW   = dmsp_pkg::DRIVE_W;

  localparam logic signed [PW:0] ISUM_HI = (PW+1)'(64'sd2147483647);
  localparam logic signed [PW:0] ISUM_LO = (PW+1)'(-64'sd2147483648);

  // per-motor state
  logic [TW-1:0]        last_time_r [MOTOR_COUNT];
  logic signed [IW-1:0] integ_r     [MOTOR_COUNT];
  logic signed [EW-1:0] prior_err_r [MOTOR_COUNT];

  // working registers for the word in flight
  logic                 sel_r;
  logic                 neg_r;
  logic                 zero_r;
  logic [MIW-1:0]       idx_r;
  logic signed [EW-1:0] err_r;
  logic [TW-1:0]        elapsed_r;
  logic                 ezero_r;
  logic [TW-1:0]        now_r;
  logic signed [IW-1:0] isum_old_r;
  logic signed [EW-1:0] prior_r;
  logic signed [IW-1:0] isum_r;
  logic signed [PW-1:0] prod_r;
  logic signed [ACW-1:0] acc_r;

  // divider
  logic [QW-1:0]  dq_r;
  logic [TW-1:0]  rem_r;
  logic [DCW-1:0] dcnt_r;
  logic           dneg_r;
  logic           div_busy_r;

  // output register
  logic                 out_valid_r;
  logic                 out_motor_r;
  logic signed [DW-1:0] out_drive_r;
  logic                 out_clamped_r;

  // load-time logic
  logic [MIW-1:0]       idx_in;
  logic signed [EW-1:0] des_ext;
  logic signed [EW-1:0] mag_in;
  logic signed [EW-1:0] err_in;
  logic [TW-1:0]        elapsed_in;

  always_comb begin
    idx_in = (int'(in_motor_sel) < MOTOR_COUNT) ? MIW'(in_motor_sel)
                                                : MIW'(MOTOR_COUNT - 1);
    des_ext    = {{(EW-SPEED_BITS){in_desired_speed[SPEED_BITS-1]}}, in_desired_speed};
    mag_in     = in_desired_speed[SPEED_BITS-1] ? -des_ext : des_ext;
    err_in     = mag_in - $signed({{(EW-dmsp_pkg::MEAS_W){1'b0}}, in_measured_speed});
    elapsed_in = in_time_ms - last_time_r[idx_in];
  end

  // shared multiplier operands: AW bits by BW bits, signed
  logic signed [EW:0]   deriv;
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;

  always_comb begin
    deriv = '0;
    if (!ezero_r) begin
      deriv = dneg_r ? -$signed({1'b0, dq_r}) : $signed({1'b0, dq_r});
    end
    unique case (cmd.mul_sel)
      dmsp_pkg::MUL_ERR_TIME: begin
        mul_a = $signed({1'b0, elapsed_r});
        mul_b = BW'(err_r);
      end
      dmsp_pkg::MUL_PROP: begin
        mul_a = AW'(err_r);
        mul_b = $signed(BW'(cfg.prop_gain));
      end
      dmsp_pkg::MUL_INTEG: begin
        mul_a = AW'(isum_r);
        mul_b = $signed(BW'(cfg.integral_gain));
      end
      dmsp_pkg::MUL_DERIV: begin
        mul_a = AW'(deriv);
        mul_b = $signed(BW'(cfg.deriv_gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // saturating integral update
  logic signed [PW:0]   isum_wide;
  logic signed [IW-1:0] isum_nxt;

  always_comb begin
    isum_wide = $signed({{(PW+1-IW){isum_old_r[IW-1]}}, isum_old_r})
              + $signed({prod_r[PW-1], prod_r});
    priority if (isum_wide > ISUM_HI) begin
      isum_nxt = ISUM_HI[IW-1:0];
    end else if (isum_wide < ISUM_LO) begin
      isum_nxt = ISUM_LO[IW-1:0];
    end else begin
      isum_nxt = isum_wide[IW-1:0];
    end
  end

  // one restoring divide step
  logic [TW:0] trial;
  logic        trial_ge;
  logic signed [EW:0] diff;

  always_comb begin
    trial    = {rem_r, dq_r[QW-1]};
    trial_ge = (trial >= {1'b0, elapsed_r});
    diff     = {err_r[EW-1], err_r} - {prior_r[EW-1], prior_r};
  end

  // floor of the Q44.8 sum, clamp and direction
  logic signed [ACW-1:0] pid;
  logic signed [ACW-1:0] lim_ext;
  logic signed [DW-1:0]  pid_c;
  logic                  clip;
  logic signed [DW-1:0]  drive_nxt;
  logic                  clamped_nxt;

  always_comb begin
    pid     = acc_r >>> dmsp_pkg::FRAC_BITS;
    lim_ext = $signed({{(ACW-dmsp_pkg::LIMIT_W){1'b0}}, cfg.drive_limit});
    priority if (pid > lim_ext) begin
      pid_c = DW'(lim_ext);
      clip  = 1'b1;
    end else if (pid < -lim_ext) begin
      pid_c = DW'(-lim_ext);
      clip  = 1'b1;
    end else begin
      pid_c = DW'(pid);
      clip  = 1'b0;
    end
    if (zero_r) begin
      drive_nxt   = '0;
      clamped_nxt = 1'b0;
    end else begin
      drive_nxt   = neg_r ? -pid_c : pid_c;
      clamped_nxt = clip;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a) * PW'(mul_b);
    if (cmd.load) begin
      sel_r      <= in_motor_sel;
      neg_r      <= in_desired_speed[SPEED_BITS-1];
      zero_r     <= (in_desired_speed == '0);
      idx_r      <= idx_in;
      err_r      <= err_in;
      elapsed_r  <= elapsed_in;
      ezero_r    <= (elapsed_in == '0);
      now_r      <= in_time_ms;
      isum_old_r <= integ_r[idx_in];
      prior_r    <= prior_err_r[idx_in];
    end
    if (cmd.isum_en) begin
      isum_r <= isum_nxt;
    end
    if (cmd.acc_clr) begin
      acc_r <= {{(ACW-PW){prod_r[PW-1]}}, prod_r};
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {{(ACW-PW){prod_r[PW-1]}}, prod_r};
    end
    if (cmd.div_start) begin
      dq_r   <= diff[EW] ? QW'(-diff) : QW'(diff);
      dneg_r <= diff[EW];
      rem_r  <= '0;
    end else if (div_busy_r) begin
      rem_r <= trial_ge ? TW'(trial - {1'b0, elapsed_r}) : TW'(trial);
      dq_r  <= {dq_r[QW-2:0], trial_ge};
    end
    if (cmd.out_load) begin
      out_motor_r   <= sel_r;
      out_drive_r   <= drive_nxt;
      out_clamped_r <= clamped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r  <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MOTOR_COUNT; i++) begin
        last_time_r[i] <= '0;
        integ_r[i]     <= '0;
        prior_err_r[i] <= '0;
      end
    end else begin
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        dcnt_r     <= DCW'(QW);
      end else if (div_busy_r) begin
        dcnt_r     <= dcnt_r - DCW'(1);
        div_busy_r <= (dcnt_r != DCW'(1));
      end
      if (cmd.out_load) begin
        out_valid_r        <= 1'b1;
        last_time_r[idx_r] <= now_r;
        integ_r[idx_r]     <= isum_r;
        prior_err_r[idx_r] <= err_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.div_busy = div_busy_r;
  assign status.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_motor_out = out_motor_r;
  assign out_drive     = out_drive_r;
  assign out_clamped   = out_clamped_r;

endmodule

// File: hw/rtl/dual_motor_speed_pid_top.sv
// Top level of the dual motor speed PID: configuration registers, controller and datapath.
// Depends on dmsp_pkg, the three channel interfaces, dmsp_ctrl and dmsp_dp.
//
//   channel  dir  word                                          handshake
//   cfg_ch   in   index, data (register write)                  valid/ready, ready held high
//   in_ch    in   motor_sel, desired_speed, measured_speed, time_ms   valid/ready
//   out_ch   out  motor_out, drive, clamped                     valid/ready
//
// The result word goes to the output register after the multiply and accumulate steps,
// the wait on the bit-serial derivative divide (quotient width QW = max(SPEED_BITS, 15) + 1,
// 17 at SPEED_BITS = 16) and the derivative steps; in_ch.ready stays low until then, so no
// new update is taken while one is in flight. A finished word waits in the output register
// while the next update is taken, and a full output register stalls only the final step.
// Reset (rst_n low, synchronous) clears the motor state and loads the register defaults.
`timescale 1ns / 1ps

module dual_motor_speed_pid_top #(
  parameter int MOTOR_COUNT = 2,
  parameter int SPEED_BITS  = 16
) (
  input logic         clk,
  input logic         rst_n,
  dmsp_cfg_if.sink    cfg_ch,
  dmsp_in_if.sink     in_ch,
  dmsp_out_if.source  out_ch
);

  dmsp_pkg::cfg_regs_t  cfg_r;
  dmsp_pkg::dp_cmd_t    cmd;
  dmsp_pkg::dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prop_gain     <= dmsp_pkg::PROP_GAIN_RST;
      cfg_r.integral_gain <= dmsp_pkg::INTEGRAL_GAIN_RST;
      cfg_r.deriv_gain    <= dmsp_pkg::DERIV_GAIN_RST;
      cfg_r.drive_limit   <= dmsp_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_ch.valid) begin
      // drop writes to unknown indexes
      unique case (cfg_ch.index)
        dmsp_pkg::REG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_ch.data;
        dmsp_pkg::REG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_ch.data;
        dmsp_pkg::REG_DERIV_GAIN:    cfg_r.deriv_gain    <= cfg_ch.data;
        dmsp_pkg::REG_DRIVE_LIMIT:
          cfg_r.drive_limit <= cfg_ch.data[dmsp_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dmsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  dmsp_dp #(
    .MOTOR_COUNT (MOTOR_COUNT),
    .SPEED_BITS  (SPEED_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .cfg               (cfg_r),
    .in_motor_sel      (in_ch.motor_sel),
    .in_desired_speed  (in_ch.desired_speed),
    .in_measured_speed (in_ch.measured_speed),
    .in_time_ms        (in_ch.time_ms),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_motor_out     (out_ch.motor_out),
    .out_drive         (out_ch.drive),
    .out_clamped       (out_ch.clamped)
  );

endmodule

// File: tb/tb.sv
// Self-checking bench for dual_motor_speed_pid_top: directed and random speed updates on
// both motors across several register settings, each drive word checked against a local PID.
// Depends on dmsp_pkg, the dmsp_in_if/dmsp_out_if/dmsp_cfg_if channels and the top level.
`timescale 1ns / 1ps

module tb;

  localparam int      LIMIT_CYCLES = 400000;
  localparam int      LONG_HOLD    = 400;
  localparam int      SETTLE       = 40;
  localparam int      RAND_PHASES  = 6;
  localparam int      PHASE_ITEMS  = 82;
  localparam longint  ISUM_MAX     = 64'sd2147483647;
  localparam longint  ISUM_MIN     = -64'sd2147483648;

  typedef struct {
    logic                                sel;
    logic signed [15:0]                  desired;
    logic [dmsp_pkg::MEAS_W-1:0]         measured;
    logic [dmsp_pkg::TIME_W-1:0]         tms;
  } speed_update_t;

  typedef struct {
    logic                                motor;
    logic signed [dmsp_pkg::DRIVE_W-1:0] drive;
    logic                                clamped;
  } drive_word_t;

  logic clk;
  logic rst_n;

  dmsp_cfg_if                     cfg_ch ();
  dmsp_in_if #(.SPEED_BITS(16))   in_ch ();
  dmsp_out_if                     out_ch ();

  dual_motor_speed_pid_top #(
    .MOTOR_COUNT (2),
    .SPEED_BITS  (16)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // local copy of the registers and the per-motor loop state
  int                          prop_k;
  int                          integ_k;
  int                          deriv_k;
  int                          drive_lim;
  logic [dmsp_pkg::TIME_W-1:0] last_ms [2];
  int                          isum_st [2];
  int                          prev_err [2];

  speed_update_t               update_q [$];
  drive_word_t                 drive_due_q [$];
  speed_update_t               cur_update;
  logic [dmsp_pkg::TIME_W-1:0] stim_ms [2];

  int   send_idle_pct = 20;
  int   recv_idle_pct = 81;
  logic rx_hold = 1'b0;
  int   err_cnt = 0;
  int   cycle_cnt = 0;
  event hold_kick;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void apply_cfg(logic [dmsp_pkg::CFG_IDX_W-1:0] idx,
                                    logic [dmsp_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      dmsp_pkg::REG_PROP_GAIN:     prop_k    = int'(val);
      dmsp_pkg::REG_INTEGRAL_GAIN: integ_k   = int'(val);
      dmsp_pkg::REG_DERIV_GAIN:    deriv_k   = int'(val);
      dmsp_pkg::REG_DRIVE_LIMIT:   drive_lim = int'(val[dmsp_pkg::LIMIT_W-1:0]);
      default: ;
    endcase
  endfunction

  // PID step for one motor; updates that motor's state
  function automatic drive_word_t compute_drive(speed_update_t u);
    int                          m;
    logic [dmsp_pkg::TIME_W-1:0] elapsed;
    longint                      dt, mag, err, isum, deriv, acc, pid, lim;
    logic                        clip;
    drive_word_t                 w;
    m       = int'(u.sel);
    elapsed = u.tms - last_ms[m];
    dt      = longint'({32'd0, elapsed});
    mag     = (u.desired < 0) ? -longint'(u.desired) : longint'(u.desired);
    err     = mag - longint'({1'b0, u.measured});
    isum    = longint'(isum_st[m]) + err * dt;
    if (isum > ISUM_MAX) isum = ISUM_MAX;
    if (isum < ISUM_MIN) isum = ISUM_MIN;
    deriv = 0;
    if (elapsed != 0) deriv = (err - longint'(prev_err[m])) / dt;
    acc  = longint'(prop_k) * err + longint'(integ_k) * isum + longint'(deriv_k) * deriv;
    pid  = acc >>> dmsp_pkg::FRAC_BITS;
    lim  = longint'(drive_lim);
    clip = 1'b0;
    if (pid > lim) begin
      pid  = lim;
      clip = 1'b1;
    end else if (pid < -lim) begin
      pid  = -lim;
      clip = 1'b1;
    end
    w.motor = u.sel;
    if (u.desired == 0) begin
      w.drive   = '0;
      w.clamped = 1'b0;
    end else begin
      w.drive   = dmsp_pkg::DRIVE_W'((u.desired < 0) ? -pid : pid);
      w.clamped = clip;
    end
    last_ms[m]  = u.tms;
    isum_st[m]  = int'(isum);
    prev_err[m] = int'(err);
    return w;
  endfunction

  task automatic report(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // sender: hold the word until taken, then offer the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid          <= 1'b0;
      in_ch.motor_sel      <= 1'b0;
      in_ch.desired_speed  <= '0;
      in_ch.measured_speed <= '0;
      in_ch.time_ms        <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) drive_due_q.push_back(compute_drive(cur_update));
      if (!in_ch.valid || in_ch.ready) begin
        if (update_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_update           = update_q.pop_front();
          in_ch.motor_sel      <= cur_update.sel;
          in_ch.desired_speed  <= cur_update.desired;
          in_ch.measured_speed <= cur_update.measured;
          in_ch.time_ms        <= cur_update.tms;
          in_ch.valid          <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each taken word against the oldest prediction
  always @(posedge clk) begin
    drive_word_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_due_q.size() == 0) begin
          report($sformatf("drive word with none pending: motor %0d drive %0d",
                           out_ch.motor_out, out_ch.drive));
        end else begin
          want = drive_due_q.pop_front();
          if (out_ch.motor_out !== want.motor)
            report($sformatf("motor_out got %b want %b", out_ch.motor_out, want.motor));
          if (out_ch.drive !== want.drive)
            report($sformatf("motor %0d drive got %0d want %0d",
                             want.motor, out_ch.drive, want.drive));
          if (out_ch.clamped !== want.clamped)
            report($sformatf("motor %0d clamped got %b want %b",
                             want.motor, out_ch.clamped, want.clamped));
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off so the block backs up into its input
  always begin
    @(hold_kick);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic cfg_write(logic [dmsp_pkg::CFG_IDX_W-1:0] idx,
                           logic [dmsp_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_cfg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic push_update(logic sel, logic signed [15:0] desired,
                             logic [dmsp_pkg::MEAS_W-1:0] measured,
                             logic [dmsp_pkg::TIME_W-1:0] tms);
    speed_update_t u;
    u.sel      = sel;
    u.desired  = desired;
    u.measured = measured;
    u.tms      = tms;
    update_q.push_back(u);
  endtask

  // wait for every word to go out, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk); while (update_q.size() != 0 || in_ch.valid || drive_due_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // mostly steady control traffic on a rising clock, with some noise
  function automatic speed_update_t next_update();
    speed_update_t u;
    int            r, mag, meas;
    r     = $urandom_range(99);
    u.sel = 1'($urandom);
    mag   = $urandom_range(0, 3000);
    meas  = mag + $urandom_range(0, 400) - 200;
    if (meas < 0) meas = 0;
    u.desired  = 16'($urandom_range(1) ? -mag : mag);
    u.measured = dmsp_pkg::MEAS_W'(meas);
    if (r < 70) begin
      stim_ms[u.sel] = stim_ms[u.sel] + $urandom_range(1, 50);
    end else if (r < 78) begin
      // same timestamp again: no derivative
    end else if (r < 86) begin
      stim_ms[u.sel] = $urandom;
    end else if (r < 92) begin
      u.desired = '0;
      stim_ms[u.sel] = stim_ms[u.sel] + $urandom_range(0, 20);
    end else begin
      u.desired  = 16'($urandom);
      u.measured = dmsp_pkg::MEAS_W'($urandom);
      stim_ms[u.sel] = stim_ms[u.sel] + $urandom_range(0, 100000);
    end
    u.tms = stim_ms[u.sel];
    return u;
  endfunction

  initial begin
    logic [dmsp_pkg::CFG_DATA_W-1:0] g [4];
    rst_n                = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    stim_ms[0]           = '0;
    stim_ms[1]           = '0;
    prop_k               = int'(dmsp_pkg::PROP_GAIN_RST);
    integ_k              = int'(dmsp_pkg::INTEGRAL_GAIN_RST);
    deriv_k              = int'(dmsp_pkg::DERIV_GAIN_RST);
    drive_lim            = int'(dmsp_pkg::DRIVE_LIMIT_RST);
    for (int i = 0; i < 2; i++) begin
      last_ms[i]  = '0;
      isum_st[i]  = 0;
      prev_err[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset gains: plain proportional, limit 255
    @(negedge clk);
    push_update(1'b0, 16'sd100, 15'd0, 32'd10);
    push_update(1'b1, -16'sd100, 15'd20, 32'd10);
    push_update(1'b0, 16'sh7FFF, 15'd0, 32'd20);
    push_update(1'b1, 16'sh8000, 15'd0, 32'd20);
    push_update(1'b0, 16'sd0, 15'd500, 32'd30);
    push_update(1'b0, 16'sd10, 15'h7FFF, 32'd30);
    push_update(1'b1, 16'sd255, 15'd0, 32'd40);
    push_update(1'b1, -16'sd256, 15'd1, 32'd50);
    push_update(1'b0, 16'sd1, 15'd0, 32'hFFFF_FFF0);
    push_update(1'b0, 16'sd1, 15'd0, 32'h0000_0005);
    push_update(1'b1, 16'sd300, 15'd100, 32'd45);
    wait_idle();

    // full PID, limit written with its top bit set, stray indexes ignored
    cfg_write(dmsp_pkg::REG_PROP_GAIN, 16'h0100);
    cfg_write(dmsp_pkg::REG_INTEGRAL_GAIN, 16'h0040);
    cfg_write(dmsp_pkg::REG_DERIV_GAIN, 16'hFFFF);
    cfg_write(dmsp_pkg::REG_DRIVE_LIMIT, 16'hFFFF);
    cfg_write(8'd200, 16'h1234);
    cfg_write(8'hFF, 16'h0000);
    @(negedge clk);
    push_update(1'b0, 16'sd1000, 15'd0, 32'd100);
    push_update(1'b0, 16'sd1000, 15'd900, 32'd100);
    push_update(1'b0, 16'sd1000, 15'd0, 32'd101);
    push_update(1'b1, 16'sh8000, 15'd0, 32'h7FFF_FFFF);
    push_update(1'b1, 16'sh8000, 15'd0, 32'hFFFF_FFFF);
    push_update(1'b1, 16'sd1, 15'h7FFF, 32'h7FFF_FFFE);
    push_update(1'b0, 16'sd0, 15'h7FFF, 32'd200);
    push_update(1'b0, 16'sh7FFF, 15'h7FFF, 32'd300);
    push_update(1'b1, 16'sh8001, 15'd5, 32'd310);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        1: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: g = '{16'h0000, 16'h0000, 16'h0000, 16'h0000};
        3: g = '{16'($urandom_range(0, 1024)), 16'($urandom_range(0, 16)),
                 16'($urandom_range(0, 4096)), 16'($urandom_range(50, 2000))};
        4: g = '{dmsp_pkg::PROP_GAIN_RST, dmsp_pkg::INTEGRAL_GAIN_RST,
                 dmsp_pkg::DERIV_GAIN_RST, 16'(dmsp_pkg::DRIVE_LIMIT_RST)};
        default: g = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      cfg_write(dmsp_pkg::REG_PROP_GAIN, g[0]);
      cfg_write(dmsp_pkg::REG_INTEGRAL_GAIN, g[1]);
      cfg_write(dmsp_pkg::REG_DERIV_GAIN, g[2]);
      cfg_write(dmsp_pkg::REG_DRIVE_LIMIT, g[3]);
      @(negedge clk);
      if (p == 2) begin
        send_idle_pct <= 81;
        recv_idle_pct <= 20;
      end else if (p == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) update_q.push_back(next_update());
      if (p == 0 || p == 4) -> hold_kick;
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: dual_motor_speed_pid_top.f
hw/rtl/dmsp_pkg.sv
hw/rtl/dmsp_in_if.sv
hw/rtl/dmsp_out_if.sv
hw/rtl/dmsp_cfg_if.sv
hw/rtl/dmsp_ctrl.sv
hw/rtl/dmsp_dp.sv
hw/rtl/dual_motor_speed_pid_top.sv
tb/tb.sv
